FILE: hw/rtl/aes_pkg.sv
// Package for the AES-256 ECB/CBC cipher core: payload types, register indexes,
// S-box tables and GF(2^8) helpers. No dependencies.
`default_nettype none
package aes_pkg;

	localparam int NumRounds = 14;
	localparam int SchedWords = 60;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY0 = 3'd0, REG_KEY1 = 3'd1, REG_KEY2 = 3'd2, REG_KEY3 = 3'd3,
		REG_IV_HI = 3'd4, REG_IV_LO = 3'd5, REG_MODE = 3'd6, REG_DIR = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic        first_block;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic       load;      // take a new block and do the initial key add
		logic       round;     // perform one round
		logic       last;      // final round (no column mix)
		logic       ks_start;  // restart key expansion
		logic       ks_step;   // expand one more schedule word
	} dp_cmd_t;

	typedef struct packed {
		logic ks_done;
	} dp_stat_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) p = p ^ x;
			x = xtime(x);
		end
		return p;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] bs;
		r = 8'h01;
		bs = x;
		for (int k = 0; k < 8; k++) begin
			if (k != 0) r = gmul(r, bs);
			bs = gmul(bs, bs);
		end
		return r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
		return 8'((v << n) | (v >> (8 - n)));
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] x);
		logic [7:0] b;
		b = ginv(x);
		return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sbox_calc(input logic [7:0] x);
		return ginv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
	endfunction

	typedef logic [7:0] sbox_arr_t [256];

	function automatic sbox_arr_t build_sbox(input logic inv);
		sbox_arr_t t;
		for (int i = 0; i < 256; i++)
			t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
		return t;
	endfunction

	localparam sbox_arr_t SBOX = build_sbox(1'b0);
	localparam sbox_arr_t INV_SBOX = build_sbox(1'b1);

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [31:0] mix_word(input logic [31:0] w);
		logic [7:0] a0, a1, a2, a3;
		a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
		return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
	endfunction

	function automatic logic [31:0] inv_mix_word(input logic [31:0] w);
		logic [7:0] a0, a1, a2, a3;
		a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
		return {gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9),
			gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13),
			gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11),
			gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14)};
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aes256_ecb_cbc_cipher_core.sv
// Top level of the AES-256 ECB/CBC cipher core: configuration registers,
// controller and datapath. Depends on aes_pkg, aes_ctrl, aes_datapath.
//
// Channel  | Direction | Handshake       | Payload
// in       | input     | in_valid/stall  | in_item_t
// out      | output    | out_valid/stall | out_item_t
// cfg      | input     | cfg_we          | cfg_index, cfg_data
//
// A block goes through a load with key whitening, then fourteen rounds
// through the single shared round unit. A key write restarts expansion, one
// schedule word a cycle (a wait, then the schedule steps, then the exit),
// during which no block is taken; the same holds after reset. A finished
// block waits in the state register while stalled; a new block is taken in
// the cycle the result transfers.
`default_nettype none
module aes256_ecb_cbc_cipher_core
	import aes_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIdxW-1:0]   cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data
);

	logic [255:0] key_q;
	logic [127:0] iv_q;
	logic cbc_q, dec_q;
	logic key_write;
	dp_cmd_t cmd;
	dp_stat_t stat;

	assign key_write = cfg_we && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
		cfg_index == REG_KEY2 || cfg_index == REG_KEY3);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q <= '0;
			cbc_q <= 1'b0;
			dec_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY0: key_q[255:192] <= cfg_data;
				REG_KEY1: key_q[191:128] <= cfg_data;
				REG_KEY2: key_q[127:64] <= cfg_data;
				REG_KEY3: key_q[63:0] <= cfg_data;
				REG_IV_HI: iv_q[127:64] <= cfg_data;
				REG_IV_LO: iv_q[63:0] <= cfg_data;
				REG_MODE: cbc_q <= cfg_data[0];
				REG_DIR: dec_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	aes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .key_write(key_write),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	aes_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_item(in_data), .key(key_q), .iv(iv_q), .cbc(cbc_q), .dec(dec_q),
		.out_item(out_data)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/aes_datapath.sv
// Datapath of the AES-256 core: key schedule memories, round unit, CBC chain.
// Depends on aes_pkg.
`default_nettype none
module aes_datapath
	import aes_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	output dp_stat_t        stat,
	input  wire in_item_t   in_item,
	input  wire logic [255:0] key,
	input  wire logic [127:0] iv,
	input  wire logic       cbc,
	input  wire logic       dec,
	output out_item_t       out_item
);

	// Schedule held as one 128-bit round key per entry, filled a word per expansion step.
	logic [127:0] enc_mem [NumRounds+1];
	logic [127:0] dec_mem [NumRounds+1];
	logic [31:0] win_q [8];           // sliding window of the last eight words
	logic [5:0]  ks_idx_q;
	logic [7:0]  rcon_q;
	logic [127:0] state_q;
	logic [127:0] chain_q;
	logic [127:0] in_save_q;
	logic [3:0]  rnd_q;
	logic [127:0] rk_q;
	logic [127:0] rk_enc0_q;
	logic [127:0] rk_dec0_q;

	// Key expansion: one word per step.
	logic [31:0] ks_t, ks_new;
	always_comb begin
		ks_t = win_q[7];
		if (ks_idx_q[2:0] == 3'd0)
			ks_t = sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'h0};
		else if (ks_idx_q[2:0] == 3'd4)
			ks_t = sub_word(win_q[7]);
		ks_new = win_q[0] ^ ks_t;
	end
	assign stat.ks_done = (ks_idx_q == 6'(SchedWords));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_idx_q <= 6'd0;
			rcon_q <= 8'h01;
		end else if (cmd.ks_start) begin
			ks_idx_q <= 6'd0;
			rcon_q <= 8'h01;
		end else if (cmd.ks_step && !stat.ks_done) begin
			ks_idx_q <= ks_idx_q + 6'd1;
			if (ks_idx_q >= 6'd8 && ks_idx_q[2:0] == 3'd0) rcon_q <= xtime(rcon_q);
		end
	end

	logic [31:0] ks_word;
	assign ks_word = (ks_idx_q < 6'd8) ? key[255 - 32*ks_idx_q[2:0] -: 32] : ks_new;

	always_ff @(posedge clk) begin
		if (cmd.ks_step && !stat.ks_done) begin
			for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
			win_q[7] <= ks_word;
		end
	end

	// Decrypt words 4..55 go through InvMixColumns on the way in.
	always_ff @(posedge clk) begin
		if (cmd.ks_step && !stat.ks_done) begin
			enc_mem[ks_idx_q[5:2]][127 - 32*ks_idx_q[1:0] -: 32] <= ks_word;
			dec_mem[ks_idx_q[5:2]][127 - 32*ks_idx_q[1:0] -: 32] <=
				(ks_idx_q < 6'd4 || ks_idx_q >= 6'(4*NumRounds)) ?
				ks_word : inv_mix_word(ks_word);
		end
	end

	// Round key fetch: one registered read for the next round.
	logic [3:0] next_rnd;
	always_comb begin
		if (cmd.load) next_rnd = dec ? 4'(NumRounds - 1) : 4'd1;
		else next_rnd = dec ? rnd_q - 4'd1 : rnd_q + 4'd1;
	end
	always_ff @(posedge clk) begin
		if (cmd.load || (cmd.round && !cmd.last))
			rk_q <= dec ? dec_mem[next_rnd] : enc_mem[next_rnd];
	end

	// Whitening keys for both directions, read every cycle.
	always_ff @(posedge clk) begin
		rk_enc0_q <= enc_mem[0];
		rk_dec0_q <= dec_mem[NumRounds];
	end

	// Initial whitening with the first round key, CBC xor on encrypt.
	logic [127:0] blk, first_rk;
	assign blk = {in_item.block_high, in_item.block_low};
	assign first_rk = dec ? rk_dec0_q : rk_enc0_q;
	logic [127:0] chain_use;
	assign chain_use = (in_item.first_block) ? iv : chain_q;

	// One round of the forward or equivalent inverse cipher.
	logic [127:0] rnd_out;
	always_comb begin
		logic [31:0] w;
		for (int c = 0; c < 4; c++) begin
			w = 32'h0;
			for (int r = 0; r < 4; r++) begin
				if (dec)
					w[31 - 8*r -: 8] = INV_SBOX[state_q[127 - 32*((c - r + 4) % 4) - 8*r -: 8]];
				else
					w[31 - 8*r -: 8] = SBOX[state_q[127 - 32*((c + r) % 4) - 8*r -: 8]];
			end
			if (!cmd.last) w = dec ? inv_mix_word(w) : mix_word(w);
			rnd_out[127 - 32*c -: 32] = w ^ rk_q[127 - 32*c -: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			rnd_q <= 4'd0;
		end else begin
			if (cmd.load) begin
				rnd_q <= next_rnd;
				if (cbc) begin
					if (dec) chain_q <= blk;
					else if (in_item.first_block) chain_q <= iv;
				end
			end else if (cmd.round) begin
				rnd_q <= next_rnd;
				if (cmd.last && cbc && !dec) chain_q <= rnd_out;
			end
		end
	end

	// For decrypt the chain used on output is the one held before this block, or the IV on a first block.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= (cbc && !dec) ? (blk ^ chain_use ^ first_rk) : (blk ^ first_rk);
			in_save_q <= (cbc && dec) ? chain_use : 128'h0;
		end else if (cmd.round) begin
			state_q <= (cmd.last && dec) ? (rnd_out ^ in_save_q) : rnd_out;
		end
	end

	assign out_item.result_high = state_q[127:64];
	assign out_item.result_low = state_q[63:0];

endmodule
`default_nettype wire

FILE: hw/rtl/aes_ctrl.sv
// Controller of the AES-256 core: key expansion sequencing, round count,
// input and output handshakes. Depends on aes_pkg.
`default_nettype none
module aes_ctrl
	import aes_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic key_write,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t   cmd
);

	typedef enum logic [1:0] {S_KEYS, S_IDLE, S_ROUND, S_DONE} state_t;
	state_t state_q;
	logic [3:0] cnt_q;
	logic ks_pend_q;

	logic in_xfer;
	assign in_stall = !(state_q == S_IDLE || (state_q == S_DONE && !out_stall));
	assign in_xfer = in_valid && !in_stall;
	assign out_valid = (state_q == S_DONE);

	always_comb begin
		cmd = '0;
		cmd.ks_start = key_write;
		cmd.ks_step = (state_q == S_KEYS) && !key_write && !ks_pend_q;
		cmd.load = in_xfer;
		cmd.round = (state_q == S_ROUND);
		cmd.last = (state_q == S_ROUND) && (cnt_q == 4'd1);
	end

	// Sequencer: keys, then one round per cycle, then hold the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_KEYS;
			cnt_q <= 4'd0;
			ks_pend_q <= 1'b1;
		end else begin
			ks_pend_q <= key_write;
			if (key_write) state_q <= S_KEYS;
			else begin
				case (state_q)
					S_KEYS: if (stat.ks_done && !ks_pend_q) state_q <= S_IDLE;
					S_IDLE, S_DONE: begin
						if (in_xfer) begin
							state_q <= S_ROUND;
							cnt_q <= 4'(NumRounds);
						end else if (state_q == S_DONE && !out_stall) begin
							state_q <= S_IDLE;
						end
					end
					S_ROUND: begin
						cnt_q <= cnt_q - 4'd1;
						if (cnt_q == 4'd1) state_q <= S_DONE;
					end
					default: state_q <= S_KEYS;
				endcase
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_ROUND && cnt_q == 4'(NumRounds))
		else $error("load did not start rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |=> out_valid)
		else $error("last round did not raise result");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule
`default_nettype wire

FILE: dv/aes256_ecb_cbc_cipher_core_tb.sv
// Self-checking testbench for the AES-256 ECB/CBC cipher core.
// Uses aes_pkg for payload types and register indexes; predicts each block itself or takes a pinned known answer.
`default_nettype none
module aes256_ecb_cbc_cipher_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aes_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = REG_KEY0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	in_item_t            in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_data;

	aes256_ecb_cbc_cipher_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #4 clk = ~clk;

	// Predictor state: lookup tables, schedules, key and chaining registers.
	logic [7:0]  sb [256];
	logic [7:0]  isb [256];
	logic [31:0] ek [60];
	logic [31:0] dk [60];
	logic [63:0] key_word [4];
	logic [63:0] iv_hi, iv_lo, chain_hi, chain_lo;
	logic        cbc_on, decrypting;

	out_item_t   expected_blocks [$];
	logic        pin_flag [$];
	out_item_t   pin_value [$];

	int errors = 0;
	int n_in = 0, n_out = 0, n_cbc = 0, n_dec = 0;
	int stall_mode = 0;
	logic hold_go = 1'b0;
	int hold_cnt = 0;
	logic hold_done = 1'b0;
	int pat_cnt = 0;

	function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [31:0] col_mix(logic [31:0] w, logic inv);
		logic [7:0] a [4];
		logic [7:0] m [4];
		logic [31:0] r;
		for (int i = 0; i < 4; i++) a[i] = w[31-8*i -: 8];
		if (inv) begin
			m = '{8'd14, 8'd11, 8'd13, 8'd9};
		end else begin
			m = '{8'd2, 8'd3, 8'd1, 8'd1};
		end
		r = '0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				r[31-8*i -: 8] ^= gf_times(a[j], m[(j - i + 4) % 4]);
		return r;
	endfunction

	function automatic logic [31:0] word_sub(logic [31:0] w);
		return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
	endfunction

	// The tables are built from the field inverse and the affine map.
	task automatic build_tables();
		logic [7:0] v, p;
		for (int x = 0; x < 256; x++) begin
			p = 8'h01;
			for (int k = 0; k < 254; k++) p = gf_times(p, 8'(x));
			v = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]} ^ {p[3:0], p[7:4]}
				^ 8'h63;
			sb[x] = v;
			isb[v] = 8'(x);
		end
	endtask

	function automatic void schedule_keys();
		logic [31:0] t;
		logic [7:0] rc;
		rc = 8'h01;
		for (int i = 0; i < 8; i++)
			ek[i] = (i % 2 == 0) ? key_word[i/2][63:32] : key_word[i/2][31:0];
		for (int i = 8; i < 60; i++) begin
			t = ek[i-1];
			if (i % 8 == 0) begin
				t = word_sub({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_times(rc, 8'h02);
			end else if (i % 8 == 4) begin
				t = word_sub(t);
			end
			ek[i] = ek[i-8] ^ t;
		end
		for (int i = 0; i < 60; i++)
			dk[i] = (i < 4 || i >= 56) ? ek[i] : col_mix(ek[i], 1'b1);
	endfunction

	function automatic logic [127:0] block_encrypt(logic [127:0] b);
		logic [31:0] s [4];
		logic [31:0] t [4];
		logic [31:0] w;
		for (int c = 0; c < 4; c++) s[c] = b[127-32*c -: 32] ^ ek[c];
		for (int rnd = 1; rnd <= 14; rnd++) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++)
					w[31-8*r -: 8] = sb[s[(c + r) % 4][31-8*r -: 8]];
				t[c] = (rnd < 14) ? col_mix(w, 1'b0) : w;
			end
			for (int c = 0; c < 4; c++) s[c] = t[c] ^ ek[4*rnd + c];
		end
		return {s[0], s[1], s[2], s[3]};
	endfunction

	function automatic logic [127:0] block_decrypt(logic [127:0] b);
		logic [31:0] s [4];
		logic [31:0] t [4];
		logic [31:0] w;
		for (int c = 0; c < 4; c++) s[c] = b[127-32*c -: 32] ^ dk[56 + c];
		for (int rnd = 13; rnd >= 0; rnd--) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++)
					w[31-8*r -: 8] = isb[s[(c - r + 4) % 4][31-8*r -: 8]];
				t[c] = (rnd > 0) ? col_mix(w, 1'b1) : w;
			end
			for (int c = 0; c < 4; c++) s[c] = t[c] ^ dk[4*rnd + c];
		end
		return {s[0], s[1], s[2], s[3]};
	endfunction

	// Works out one output block and advances the chaining register.
	function automatic out_item_t cipher_block(in_item_t it);
		logic [127:0] x, y;
		if (cbc_on && it.first_block) begin
			chain_hi = iv_hi;
			chain_lo = iv_lo;
		end
		x = {it.block_high, it.block_low};
		if (decrypting) begin
			y = block_decrypt(x);
			if (cbc_on) begin
				y ^= {chain_hi, chain_lo};
				{chain_hi, chain_lo} = x;
			end
		end else begin
			if (cbc_on) x ^= {chain_hi, chain_lo};
			y = block_encrypt(x);
			if (cbc_on) {chain_hi, chain_lo} = y;
		end
		return y;
	endfunction

	function automatic void apply_config(cfg_reg_t idx, logic [63:0] val);
		case (idx)
			REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
				key_word[int'(idx)] = val;
				schedule_keys();
			end
			REG_IV_HI: iv_hi = val;
			REG_IV_LO: iv_lo = val;
			REG_MODE: cbc_on = val[0];
			REG_DIR: decrypting = val[0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// Monitor: predicts on every input transfer and checks every output transfer.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				e = cipher_block(in_data);
				n_in++;
				if (cbc_on) n_cbc++;
				if (decrypting) n_dec++;
				if (pin_flag.size() != 0) begin
					if (pin_flag.pop_front()) begin
						e = pin_value.pop_front();
					end else begin
						void'(pin_value.pop_front());
					end
				end
				expected_blocks.push_back(e);
			end
			if (out_valid && !out_stall) begin
				n_out++;
				if (expected_blocks.size() == 0) begin
					report_mismatch("unexpected result_high", out_data.result_high, '0);
				end else begin
					e = expected_blocks.pop_front();
					if (out_data.result_high !== e.result_high)
						report_mismatch("result_high", out_data.result_high, e.result_high);
					if (out_data.result_low !== e.result_low)
						report_mismatch("result_low", out_data.result_low, e.result_low);
				end
			end
		end
	end

	// Receiver back-pressure: a long hold on request, otherwise the current pattern.
	always @(posedge clk) begin
		pat_cnt++;
		if (hold_go && !hold_done) begin
			hold_cnt = 400;
			hold_done = 1'b1;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				3: out_stall <= (pat_cnt % 16 >= 11);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic send_block(in_item_t it, logic pinned, out_item_t pv);
		pin_flag.push_back(pinned);
		pin_value.push_back(pv);
		cfg_we <= 1'b0;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_gap(int n);
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		while (expected_blocks.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [63:0] val);
		in_valid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		apply_config(idx, val);
	endtask

	typedef struct {
		logic      is_cfg;
		cfg_reg_t  idx;
		logic [63:0] val;
		in_item_t  it;
		logic      pinned;
		out_item_t pv;
	} stim_row_t;

	stim_row_t stim_table [$];

	function automatic void row_cfg(cfg_reg_t idx, logic [63:0] val);
		stim_table.push_back('{1'b1, idx, val, '0, 1'b0, '0});
	endfunction

	function automatic void row_item(logic [63:0] h, logic [63:0] l, logic f,
			logic pinned, logic [127:0] pv);
		stim_table.push_back('{1'b0, REG_KEY0, '0, '{h, l, f}, pinned, pv});
	endfunction

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		logic sent_since_drain;
		logic [63:0] h, l;
		int burst, msg_left, nitems;
		in_item_t it;

		build_tables();
		key_word = '{default: '0};
		iv_hi = '0; iv_lo = '0; chain_hi = '0; chain_lo = '0;
		cbc_on = 1'b0; decrypting = 1'b0;
		schedule_keys();

		// Directed part: extremes, the standard vector both ways, CBC corner cases.
		row_item('0, '0, 1'b0, 1'b1, 128'hdc95c078a2408989ad48a21492842087);
		row_item('1, '1, 1'b1, 1'b0, '0);
		row_item('1, '0, 1'b0, 1'b0, '0);
		row_cfg(REG_KEY0, 64'h0001020304050607);
		row_cfg(REG_KEY1, 64'h08090a0b0c0d0e0f);
		row_cfg(REG_KEY2, 64'h1011121314151617);
		row_cfg(REG_KEY3, 64'h18191a1b1c1d1e1f);
		row_item(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b1,
			128'h8ea2b7ca516745bfeafc49904b496089);
		row_cfg(REG_DIR, 64'd1);
		row_item(64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b0, 1'b1,
			128'h00112233445566778899aabbccddeeff);
		// CBC decrypt with no first block yet: the chain still holds zero.
		row_cfg(REG_MODE, 64'd1);
		row_item(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0, '0);
		// A fresh IV only counts once a first block arrives.
		row_cfg(REG_IV_HI, 64'hffffffffffffffff);
		row_cfg(REG_IV_LO, 64'h5a5a5a5aa5a5a5a5);
		row_item('0, '1, 1'b0, 1'b0, '0);
		row_item('1, '0, 1'b1, 1'b0, '0);
		row_item(64'h8000000000000001, 64'h1, 1'b0, 1'b0, '0);
		// Direction change in the middle of a message.
		row_cfg(REG_DIR, 64'd0);
		row_item('0, '0, 1'b0, 1'b0, '0);
		row_item('1, '1, 1'b1, 1'b0, '0);
		row_item(64'hdeadbeefcafef00d, '1, 1'b0, 1'b0, '0);
		// Wide values are cut to one bit.
		row_cfg(REG_MODE, 64'hfffffffffffffffe);
		row_item('1, '1, 1'b1, 1'b0, '0);
		row_cfg(REG_KEY0, '1);
		row_cfg(REG_KEY3, '1);
		row_item('0, '1, 1'b0, 1'b0, '0);
		row_cfg(REG_DIR, '1);
		row_item('1, '0, 1'b1, 1'b0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sent_since_drain = 1'b1;
		foreach (stim_table[i]) begin
			if (stim_table[i].is_cfg) begin
				if (sent_since_drain) wait_drained();
				sent_since_drain = 1'b0;
				cfg_write(stim_table[i].idx, stim_table[i].val);
			end else begin
				send_block(stim_table[i].it, stim_table[i].pinned, stim_table[i].pv);
				sent_since_drain = 1'b1;
			end
		end

		// Random part: phases of fresh settings, then messages under varying pressure.
		for (int ph = 0; ph < 10; ph++) begin
			wait_drained();
			stall_mode = ph % 4;
			for (int r = 0; r < 8; r++) cfg_write(cfg_reg_t'(r), rand64());
			if (ph < 4) begin
				cfg_write(REG_MODE, 64'(ph % 2));
				cfg_write(REG_DIR, 64'(ph / 2));
			end
			msg_left = 0;
			burst = 0;
			nitems = 120;
			for (int k = 0; k < nitems; k++) begin
				if (ph == 3 && k == 40) hold_go = 1'b1;
				if (ph == 5 && k == 60) wait_drained();
				// From phase six on, mode or direction gets a random value mid-message.
				if (ph >= 6 && k == 70) begin
					wait_drained();
					cfg_write($urandom_range(0, 1) ? REG_MODE : REG_DIR, rand64());
				end
				if (burst == 0 && ph != 2) begin
					idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
					burst = $urandom_range(1, 20);
				end
				if (burst > 0) burst--;
				h = rand64();
				l = rand64();
				if (msg_left == 0) begin
					msg_left = $urandom_range(1, 12);
					it = '{h, l, 1'b1};
				end else begin
					it = '{h, l, ($urandom_range(0, 9) == 0)};
				end
				msg_left--;
				send_block(it, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		stall_mode = 1;
		while (expected_blocks.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d blocks in and %0d out: %0d chained, %0d decrypted.",
			n_in, n_out, n_cbc, n_dec);
		$display("Key, IV, mode and direction all rewritten across the phases.");
		if (errors == 0 && expected_blocks.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_datapath.sv
hw/rtl/aes_ctrl.sv
hw/rtl/aes256_ecb_cbc_cipher_core.sv
dv/aes256_ecb_cbc_cipher_core_tb.sv
